// ----- sv/qst_pkg.sv -----
// qst_pkg: shared types and constants of the query string tokenizer
// holds the op and result records, parse phase and status codes
// no dependencies
package qst_pkg;

  localparam int MaxPairs = 64;
  localparam int MaxLen   = 4096;

  localparam int OffW = 12;
  localparam int LenW = 13;
  localparam int IdxW = 6;
  localparam int CntW = 7;

  localparam logic [7:0] ChEq  = 8'h3D;
  localparam logic [7:0] ChAmp = 8'h26;

  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic REQ_DATA = 1'b0;

  typedef enum logic [1:0] {
    PH_KEY_START,
    PH_KEY,
    PH_VALUE_START,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    OP_DATA,
    OP_EQ,
    OP_AMP,
    OP_END
  } op_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_TOO_MANY,
    ST_TOO_LONG
  } status_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } op_slot_t;

  typedef struct packed {
    logic            kind;
    logic [OffW-1:0] key_offset;
    logic [LenW-1:0] key_length;
    logic            value_present;
    logic [OffW-1:0] value_offset;
    logic [LenW-1:0] value_length;
    logic [IdxW-1:0] pair_index;
    status_t         status;
    logic [CntW-1:0] pair_count;
    logic            last;
  } res_t;

endpackage

// ----- sv/qst_front.sv -----
// qst_front: input side of the tokenizer, classifies each byte into an op
// and holds ops in a short queue for the back stage
// depends on qst_pkg
module qst_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  output logic             full,
  input  logic             in_req_type,
  input  logic [7:0]       in_data_byte,
  output qst_pkg::op_slot_t head,
  input  logic             head_pop
);
  import qst_pkg::*;

  op_t              q_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt;
  logic [QPtrW-1:0] rd_r, rd_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  op_t              op_in;
  logic             accept;
  logic             do_pop;

  // classify the byte, the end marker wins over its data
  always_comb begin
    if (in_req_type != REQ_DATA) begin
      op_in = OP_END;
    end else if (in_data_byte == ChEq) begin
      op_in = OP_EQ;
    end else if (in_data_byte == ChAmp) begin
      op_in = OP_AMP;
    end else begin
      op_in = OP_DATA;
    end
  end

  assign full   = (cnt_r == QCntW'(QDepth));
  assign accept = push && !full;
  assign do_pop = head_pop && (cnt_r != '0);

  always_comb begin
    wr_nxt  = accept ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_pop ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (accept && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!accept && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      q_r[wr_r] <= op_in;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.op    = q_r[rd_r];

endmodule

// ----- sv/qst_back.sv -----
// qst_back: parse state machine of the tokenizer, turns ops into span
// and done records, at most one record per cycle while the result queue has room
// depends on qst_pkg
module qst_back (
  input  logic              clk,
  input  logic              rst_n,
  input  qst_pkg::op_slot_t head,
  output logic              head_pop,
  input  logic              res_full,
  output logic              res_push,
  output qst_pkg::res_t     res
);
  import qst_pkg::*;

  phase_t          phase_r, phase_nxt;
  logic [LenW-1:0] pos_r, pos_nxt;
  logic [OffW-1:0] key_start_r, key_start_nxt;
  logic [LenW-1:0] key_len_r, key_len_nxt;
  logic [OffW-1:0] value_start_r, value_start_nxt;
  logic [CntW-1:0] pairs_r, pairs_nxt;
  status_t         err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_KEY_START;
      pos_r         <= '0;
      key_start_r   <= '0;
      key_len_r     <= '0;
      value_start_r <= '0;
      pairs_r       <= '0;
      err_r         <= ST_OK;
    end else begin
      phase_r       <= phase_nxt;
      pos_r         <= pos_nxt;
      key_start_r   <= key_start_nxt;
      key_len_r     <= key_len_nxt;
      value_start_r <= value_start_nxt;
      pairs_r       <= pairs_nxt;
      err_r         <= err_nxt;
    end
  end

  always_comb begin
    logic [OffW-1:0] p;
    logic            go;
    logic            emit;
    logic            closed;
    logic            vpres;
    logic [LenW-1:0] klen;
    logic [OffW-1:0] voff;
    logic [LenW-1:0] vlen;
    logic            last;
    logic            done;

    phase_nxt       = phase_r;
    pos_nxt         = pos_r;
    key_start_nxt   = key_start_r;
    key_len_nxt     = key_len_r;
    value_start_nxt = value_start_r;
    pairs_nxt       = pairs_r;
    err_nxt         = err_r;
    head_pop        = 1'b0;

    p      = pos_r[OffW-1:0];
    go     = head.valid && !res_full;
    emit   = 1'b0;
    closed = 1'b0;
    vpres  = 1'b0;
    klen   = key_len_r;
    voff   = '0;
    vlen   = '0;
    last   = 1'b1;
    done   = 1'b0;

    if (go && (head.op != OP_END)) begin
      head_pop = 1'b1;
      if (err_r == ST_TOO_MANY) begin
        // pair limit reached, bytes up to the end marker are dropped
      end else if (pos_r >= LenW'(MaxLen)) begin
        err_nxt = ST_TOO_LONG;
      end else begin
        pos_nxt = pos_r + 1'b1;
        unique case (phase_r)
          PH_KEY_START: begin
            if (head.op == OP_DATA) begin
              key_start_nxt = p;
              phase_nxt     = PH_KEY;
            end
          end
          PH_KEY: begin
            if (head.op == OP_EQ) begin
              key_len_nxt = {1'b0, p - key_start_r};
              phase_nxt   = PH_VALUE_START;
            end else if (head.op == OP_AMP) begin
              klen        = {1'b0, p - key_start_r};
              key_len_nxt = klen;
              emit        = 1'b1;
              closed      = 1'b1;
            end
          end
          PH_VALUE_START: begin
            if (head.op != OP_DATA) begin
              emit   = 1'b1;
              closed = 1'b1;
            end else begin
              value_start_nxt = p;
              phase_nxt       = PH_VALUE;
            end
          end
          PH_VALUE: begin
            if (head.op == OP_AMP) begin
              vpres  = 1'b1;
              voff   = value_start_r;
              vlen   = {1'b0, p - value_start_r};
              emit   = 1'b1;
              closed = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end else if (go) begin
      if (phase_r != PH_KEY_START) begin
        // trailing pair first, the end marker stays queued and the done record follows it
        emit      = 1'b1;
        last      = 1'b0;
        phase_nxt = PH_KEY_START;
        if (phase_r == PH_KEY) begin
          klen        = pos_r - {1'b0, key_start_r};
          key_len_nxt = klen;
        end else if (phase_r == PH_VALUE) begin
          vpres = 1'b1;
          voff  = value_start_r;
          vlen  = pos_r - {1'b0, value_start_r};
        end
        pairs_nxt = pairs_r + 1'b1;
      end else begin
        done            = 1'b1;
        head_pop        = 1'b1;
        phase_nxt       = PH_KEY_START;
        pos_nxt         = '0;
        key_start_nxt   = '0;
        key_len_nxt     = '0;
        value_start_nxt = '0;
        pairs_nxt       = '0;
        err_nxt         = ST_OK;
      end
    end

    if (closed) begin
      pairs_nxt = pairs_r + 1'b1;
      phase_nxt = PH_KEY_START;
      if (pairs_nxt >= CntW'(MaxPairs)) begin
        err_nxt = ST_TOO_MANY;
      end
    end

    res_push = emit || done;
    res      = '0;
    if (done) begin
      res.kind       = KIND_DONE;
      res.status     = err_r;
      res.pair_count = pairs_r;
      res.last       = 1'b1;
    end else begin
      res.kind          = KIND_PAIR;
      res.key_offset    = key_start_r;
      res.key_length    = klen;
      res.value_present = vpres;
      res.value_offset  = voff;
      res.value_length  = vlen;
      res.pair_index    = pairs_r[IdxW-1:0];
      res.status        = ST_OK;
      res.last          = last;
    end
  end

endmodule

// ----- sv/qst_res_fifo.sv -----
// qst_res_fifo: result queue of the tokenizer, parts the back stage
// from the result port
// depends on qst_pkg
module qst_res_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  qst_pkg::res_t wr_data,
  output logic          full,
  input  logic          pop,
  output qst_pkg::res_t rd_data,
  output logic          empty
);
  import qst_pkg::*;

  res_t             q_r [QDepth];
  logic [QPtrW-1:0] wr_r, wr_nxt;
  logic [QPtrW-1:0] rd_r, rd_nxt;
  logic [QCntW-1:0] cnt_r, cnt_nxt;
  logic             do_wr;
  logic             do_rd;

  assign full  = (cnt_r == QCntW'(QDepth));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = pop && !empty;

  always_comb begin
    wr_nxt  = do_wr ? wr_r + 1'b1 : wr_r;
    rd_nxt  = do_rd ? rd_r + 1'b1 : rd_r;
    cnt_nxt = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!do_wr && do_rd) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      q_r[wr_r] <= wr_data;
    end
  end

  assign rd_data = q_r[rd_r];

endmodule

// ----- sv/query_string_tokenizer_unit.sv -----
// query_string_tokenizer_unit: top level of the query string tokenizer
// depends on qst_pkg, qst_front, qst_back and qst_res_fifo
//
//   channel  | handshake           | payload
//   ---------+---------------------+-------------------------------------------
//   input    | push / full         | in_req_type, in_data_byte
//   result   | empty / pop         | out_kind .. out_last (span or done record)
//
// one byte per cycle sustained while full is low; a result shows on the result
// ports after its transaction is accepted, held once in the op queue and once in
// the result queue
// an end marker that flushes a trailing pair stays in the op queue while the back
// stage writes the pair record, and is taken with the done record
// reset is synchronous and clears both queues and the parse state at once
// full rises when the four-entry op queue fills; the back stage stalls
// while the four-entry result queue is full
module query_string_tokenizer_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      push,
  output logic                      full,
  input  logic                      in_req_type,
  input  logic [7:0]                in_data_byte,
  output logic                      empty,
  input  logic                      pop,
  output logic                      out_kind,
  output logic [qst_pkg::OffW-1:0]  out_key_offset,
  output logic [qst_pkg::LenW-1:0]  out_key_length,
  output logic                      out_value_present,
  output logic [qst_pkg::OffW-1:0]  out_value_offset,
  output logic [qst_pkg::LenW-1:0]  out_value_length,
  output logic [qst_pkg::IdxW-1:0]  out_pair_index,
  output logic [1:0]                out_status,
  output logic [qst_pkg::CntW-1:0]  out_pair_count,
  output logic                      out_last
);
  import qst_pkg::*;

  op_slot_t head;
  logic     head_pop;
  logic     res_full;
  logic     res_push;
  res_t     res;
  res_t     out_rec;

  qst_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_req_type  (in_req_type),
    .in_data_byte (in_data_byte),
    .head         (head),
    .head_pop     (head_pop)
  );

  qst_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_pop (head_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res)
  );

  qst_res_fifo u_res_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (pop),
    .rd_data (out_rec),
    .empty   (empty)
  );

  assign out_kind          = out_rec.kind;
  assign out_key_offset    = out_rec.key_offset;
  assign out_key_length    = out_rec.key_length;
  assign out_value_present = out_rec.value_present;
  assign out_value_offset  = out_rec.value_offset;
  assign out_value_length  = out_rec.value_length;
  assign out_pair_index    = out_rec.pair_index;
  assign out_status        = out_rec.status;
  assign out_pair_count    = out_rec.pair_count;
  assign out_last          = out_rec.last;

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !(res_push && res_full))
    else $error("record written into a full result queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    head_pop |-> head.valid)
    else $error("op taken from an empty op queue");

  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_DONE) |-> out_last)
    else $error("done record not marked last");

  a_pair_has_no_status: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_kind == KIND_PAIR) |-> (out_status == ST_OK && out_pair_count == '0))
    else $error("pair record carries done fields");
`endif

endmodule
